### hw/rtl/lkvc_pkg.sv
package lkvc_pkg;

  // Fixed field widths
  localparam int KEY_W = 31;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation codes
  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  // Broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic compare;   // capture key match into each cell
    logic update;    // commit this cycle's shift
    logic hit;       // the item matched a stored key
    logic insert;    // put miss, free room: grow the chain by one
    logic evict;     // put miss at capacity: oldest entry falls off
  } cell_ctrl_t;

endpackage

### hw/rtl/lkvc_if.sv
// Request channel
interface lkvc_in_if #(
  parameter int VALUE_BITS = 64
);
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [lkvc_pkg::KEY_W-1:0] lookup_key;
  logic [VALUE_BITS-1:0]     write_value;

  modport source (output valid, output operation, output lookup_key, output write_value,
                  input ready);
  modport sink (input valid, input operation, input lookup_key, input write_value,
                output ready);
endinterface

// Result channel
interface lkvc_out_if #(
  parameter int VALUE_BITS = 64
);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [VALUE_BITS-1:0] read_value;
  logic                  evicted;

  modport source (output valid, output hit, output read_value, output evicted,
                  input ready);
  modport sink (input valid, input hit, input read_value, input evicted,
                output ready);
endinterface

### hw/rtl/lkvc_cell.sv
// One entry of the recency chain. Position in the chain is the recency rank:
// cell 0 holds the most recent entry. On update a cell takes its lower
// neighbor's contents when it lies in the shifted span.
module lkvc_cell #(
  parameter int VALUE_BITS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lkvc_pkg::cell_ctrl_t        ctrl,
  input  logic [lkvc_pkg::KEY_W-1:0]  search_key,
  // from the more recent neighbor
  input  logic [lkvc_pkg::KEY_W-1:0]  prev_key,
  input  logic [VALUE_BITS-1:0]       prev_val,
  input  logic                        prev_valid,
  input  logic                        seen_in,
  input  logic [VALUE_BITS-1:0]       found_in,
  // to the less recent neighbor
  output logic [lkvc_pkg::KEY_W-1:0]  key_o,
  output logic [VALUE_BITS-1:0]       val_o,
  output logic                        valid_o,
  output logic                        seen_out,
  output logic [VALUE_BITS-1:0]       found_out
);

  logic [lkvc_pkg::KEY_W-1:0] key_r;
  logic [VALUE_BITS-1:0]      val_r;
  logic                       valid_r;
  logic                       match_r;
  logic                       shift;

  // Which cells move this update
  always_comb begin
    shift = 1'b0;
    if (ctrl.update) begin
      priority if (ctrl.hit) begin
        // cells from the head down to the matching one
        shift = !seen_in;
      end else if (ctrl.insert) begin
        shift = valid_r | prev_valid;
      end else if (ctrl.evict) begin
        shift = valid_r;
      end
    end
  end

  // Control state: valid and match flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      if (ctrl.compare) begin
        match_r <= valid_r & (key_r == search_key);
      end
      if (shift) begin
        valid_r <= prev_valid;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (shift) begin
      key_r <= prev_key;
      val_r <= prev_val;
    end
  end

  assign key_o     = key_r;
  assign val_o     = val_r;
  assign valid_o   = valid_r;
  assign seen_out  = seen_in | match_r;
  assign found_out = found_in | (match_r ? val_r : '0);

endmodule

### hw/rtl/lru_key_value_cache.sv
// Fully associative key-value cache with LRU replacement, built as a chain
// of ENTRIES cells ordered by recency (cell 0 is the most recent entry).
// Each request is a get or a put of a 31-bit key; every request returns one
// result (hit, read_value on a get hit, evicted on a put miss at capacity).
// A request is compared in all cells at once in S_LOOK; in S_UPD the match
// is carried along the chain and the entries shift by one cell. The next
// request is accepted in S_UPD once the output register is free or being
// read. A finished result waits in the output register while the next
// request is compared. capacity_limit (cfg port, reset 16, 0 acts as 1,
// clamped to ENTRIES) sets how many entries are held before eviction begins.
module lru_key_value_cache #(
  parameter int ENTRIES    = 16,
  parameter int VALUE_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lkvc_in_if.sink                       in_chan,
  lkvc_out_if.source                    out_chan,
  input  logic                          cfg_wr_en,
  input  logic [lkvc_pkg::CAP_W-1:0]    cfg_wr_data
);

  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t                      state_r, state_nxt;
  logic [lkvc_pkg::CAP_W-1:0]  cap_r;
  logic [CNT_W-1:0]            count_r;
  lkvc_pkg::op_t               op_r;
  logic [lkvc_pkg::KEY_W-1:0]  key_r;
  logic [VALUE_BITS-1:0]       wval_r;

  logic                        out_valid_r;
  logic                        out_hit_r;
  logic [VALUE_BITS-1:0]       out_rval_r;
  logic                        out_evict_r;

  logic                        upd_go;
  logic                        in_xfer;
  logic                        hit;
  logic                        is_put;
  logic                        at_cap;
  logic [VALUE_BITS-1:0]       found_val;
  lkvc_pkg::cell_ctrl_t        ctrl;

  // Chain links, index i feeds cell i
  logic [lkvc_pkg::KEY_W-1:0]  lk_key   [ENTRIES+1];
  logic [VALUE_BITS-1:0]       lk_val   [ENTRIES+1];
  logic                        lk_valid [ENTRIES+1];
  logic                        lk_seen  [ENTRIES+1];
  logic [VALUE_BITS-1:0]       lk_found [ENTRIES+1];

  // Handshake
  assign upd_go         = (state_r == S_UPD) && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = (state_r == S_IDLE) || upd_go;
  assign in_xfer        = in_chan.valid && in_chan.ready;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_LOOK;
      S_LOOK: state_nxt = S_UPD;
      S_UPD: begin
        if (upd_go) state_nxt = in_xfer ? S_LOOK : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Capacity check: limit 0 acts as 1, above ENTRIES acts as ENTRIES
  always_comb begin
    int cnt;
    int cap;
    cnt = int'(count_r);
    cap = (cap_r == '0) ? 1 : int'(cap_r);
    at_cap = (cnt >= ENTRIES) || (cnt >= cap);
  end

  assign hit       = lk_seen[ENTRIES];
  assign found_val = lk_found[ENTRIES];
  assign is_put    = (op_r == lkvc_pkg::OP_PUT);

  always_comb begin
    ctrl.compare = (state_r == S_LOOK);
    ctrl.update  = upd_go;
    ctrl.hit     = hit;
    ctrl.insert  = is_put && !hit && !at_cap;
    ctrl.evict   = is_put && !hit && at_cap;
  end

  // Head of the chain: the entry that becomes most recent
  assign lk_key[0]   = key_r;
  assign lk_val[0]   = is_put ? wval_r : found_val;
  assign lk_valid[0] = 1'b1;
  assign lk_seen[0]  = 1'b0;
  assign lk_found[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkvc_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .search_key (key_r),
      .prev_key   (lk_key[i]),
      .prev_val   (lk_val[i]),
      .prev_valid (lk_valid[i]),
      .seen_in    (lk_seen[i]),
      .found_in   (lk_found[i]),
      .key_o      (lk_key[i+1]),
      .val_o      (lk_val[i+1]),
      .valid_o    (lk_valid[i+1]),
      .seen_out   (lk_seen[i+1]),
      .found_out  (lk_found[i+1])
    );
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= lkvc_pkg::CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (upd_go && ctrl.insert) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (upd_go) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r   <= lkvc_pkg::op_t'(in_chan.operation);
      key_r  <= in_chan.lookup_key;
      wval_r <= in_chan.write_value;
    end
    if (upd_go) begin
      out_hit_r   <= hit;
      out_rval_r  <= (hit && !is_put) ? found_val : '0;
      out_evict_r <= ctrl.evict;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.hit        = out_hit_r;
  assign out_chan.read_value = out_rval_r;
  assign out_chan.evicted    = out_evict_r;

endmodule

### bench/testbench.sv
import lkvc_pkg::*;

typedef bit [KEY_W-1:0] key_t;
typedef bit [63:0]      word_t;

// One cached pair; the recency list keeps the most recent entry at index 0
typedef struct {
  key_t  key;
  word_t value;
} kv_entry_t;

// Result fields of one access
typedef struct {
  bit    hit;
  word_t read_value;
  bit    evicted;
} access_reply_t;

// Predicts each access from a recency-ordered copy of the cache contents and
// matches the block's results against the predictions in order.
class cache_scoreboard;
  kv_entry_t       recency[$];
  access_reply_t   expected_replies[$];
  bit [CAP_W-1:0]  capacity_limit;
  int              errors;

  function new();
    capacity_limit = CAP_RESET;
    errors = 0;
  endfunction

  function void set_capacity(bit [CAP_W-1:0] limit);
    capacity_limit = limit;
  endfunction

  // Zero acts as one, anything above the slot count acts as 16
  function int effective_capacity();
    int cap;
    cap = capacity_limit;
    if (cap < 1) cap = 1;
    if (cap > 16) cap = 16;
    return cap;
  endfunction

  function access_reply_t predict_access(op_t op, key_t key, word_t value);
    access_reply_t reply;
    kv_entry_t     entry;
    int            found;
    reply = '{hit: 1'b0, read_value: '0, evicted: 1'b0};
    found = -1;
    foreach (recency[i]) begin
      if (found < 0 && recency[i].key == key) found = i;
    end
    if (found >= 0) begin
      // Hit: update or read, then move to the front
      reply.hit = 1'b1;
      entry = recency[found];
      if (op == OP_PUT) entry.value = value;
      else reply.read_value = entry.value;
      recency.delete(found);
      recency.push_front(entry);
    end else if (op == OP_PUT) begin
      // Miss on a put: drop the least recent entry when full, then insert
      if (recency.size() >= effective_capacity()) begin
        void'(recency.pop_back());
        reply.evicted = 1'b1;
      end
      entry.key = key;
      entry.value = value;
      recency.push_front(entry);
    end
    return reply;
  endfunction

  function void note_request(op_t op, key_t key, word_t value);
    expected_replies.push_back(predict_access(op, key, value));
  endfunction

  function int pending();
    return expected_replies.size();
  endfunction

  task report(string msg);
    if (errors < 100) $display("MISMATCH: %s", msg);
    errors++;
  endtask

  task check_result(bit hit, word_t read_value, bit evicted);
    access_reply_t exp;
    if (expected_replies.size() == 0) begin
      report("result transfer with no request outstanding");
      return;
    end
    exp = expected_replies.pop_front();
    if (hit != exp.hit)
      report($sformatf("hit: got %0b, want %0b", hit, exp.hit));
    if (read_value != exp.read_value)
      report($sformatf("read_value: got %h, want %h", read_value, exp.read_value));
    if (evicted != exp.evicted)
      report($sformatf("evicted: got %0b, want %0b", evicted, exp.evicted));
  endtask
endclass

module testbench;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_OFF    = 200;
  localparam int PHASE_ITEMS = 64;
  localparam int POOL_SIZE   = 24;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;

  lkvc_in_if  #(.VALUE_BITS(64)) in_chan ();
  lkvc_out_if #(.VALUE_BITS(64)) out_chan ();

  cache_scoreboard sb;
  key_t key_pool[POOL_SIZE];
  bit   sender_burst;
  bit   receiver_burst;
  bit   pressure_on;
  int   hold_off_cycles;
  int   idle_cycles;

  lru_key_value_cache #(
    .ENTRIES(16),
    .VALUE_BITS(64)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offer one request after a random gap and hold it until the transfer.
  // Valid stays high afterwards; the caller follows at once with another
  // request or with wait_drained.
  task send_item(op_t op, key_t key, word_t value);
    int gap;
    gap = (sender_burst || pressure_on) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.operation <= op;
    in_chan.lookup_key <= key;
    in_chan.write_value <= value;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_request(op, key, value);
  endtask

  // Stop offering and wait until every predicted result has come back
  task wait_drained();
    in_chan.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task write_capacity(bit [CAP_W-1:0] limit);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= limit;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_capacity(limit);
  endtask

  // Mostly keys from a small pool so hits and evictions happen, some fully random
  task send_random(int span);
    op_t  op;
    key_t key;
    op = op_t'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, span)];
    else key = key_t'($urandom);
    send_item(op, key, {$urandom, $urandom});
  endtask

  // Result side: random stalls, bursts without stalls, and a long hold-off on request
  initial begin
    int stall;
    int count;
    out_chan.ready <= 1'b0;
    count = 0;
    receiver_burst = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = receiver_burst ? 0 : $urandom_range(0, 13);
      end
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      sb.check_result(out_chan.hit, out_chan.read_value, out_chan.evicted);
      count++;
      if (count % 16 == 0) receiver_burst = ($urandom_range(0, 3) == 0);
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Main sequence
  initial begin
    bit [CAP_W-1:0] caps[9];
    int span;
    sb = new();
    idle_cycles = 0;
    hold_off_cycles = 0;
    sender_burst = 1'b0;
    pressure_on = 1'b0;
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_chan.valid <= 1'b0;
    in_chan.operation <= OP_GET;
    in_chan.lookup_key <= '0;
    in_chan.write_value <= '0;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = key_t'($urandom);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty miss, extreme keys and values, overwrite, fill and evict
    send_item(OP_GET, '0, '0);
    send_item(OP_PUT, '0, '0);
    send_item(OP_PUT, '1, '1);
    send_item(OP_GET, '1, '0);
    send_item(OP_GET, '0, '1);
    send_item(OP_PUT, '0, 64'h0123_4567_89AB_CDEF);
    send_item(OP_GET, '0, '0);
    send_item(OP_PUT, 31'h2AAA_AAAA, 64'h5555_5555_5555_5555);
    send_item(OP_PUT, 31'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    for (int i = 1; i <= 12; i++)
      send_item(OP_PUT, key_t'(i * 32'h0100_0003 + 5), {$urandom, $urandom});
    // Cache now full: this put evicts the least recent entry
    send_item(OP_PUT, 31'h0BAD_0001, '1);
    send_item(OP_GET, '1, '0);
    send_item(OP_GET, '0, '0);

    // Phases over several capacities; zero first while the cache is full
    caps[0] = 5'd0;
    caps[1] = 5'd31;
    caps[2] = 5'd1;
    caps[3] = 5'd16;
    caps[4] = 5'd3;
    caps[5] = CAP_W'($urandom_range(2, 15));
    caps[6] = CAP_W'($urandom_range(17, 30));
    caps[7] = 5'd9;
    caps[8] = 5'd16;
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      span = sb.effective_capacity() + 4;
      if (span > POOL_SIZE - 1) span = POOL_SIZE - 1;
      // Fill the block while the result side holds off
      if (p == 3) begin
        hold_off_cycles = HOLD_OFF;
        pressure_on = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 16 == 0) sender_burst = ($urandom_range(0, 3) == 0);
        if (n == 24) pressure_on = 1'b0;
        if (n == 32) wait_drained();
        send_random(span);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

### lru_key_value_cache.f
hw/rtl/lkvc_pkg.sv
hw/rtl/lkvc_if.sv
hw/rtl/lkvc_cell.sv
hw/rtl/lru_key_value_cache.sv
bench/testbench.sv
